/* rtl/tbwb_pkg.sv */
// shared types and constants of the three-band waveform binning block
package tbwb_pkg;

    localparam int WINDOW_BINS_DEF = 1024;
    localparam int SAMPLE_BITS     = 24;
    localparam int MAX_CHANNELS    = 2;
    localparam int FILT_EXT        = 8;
    localparam int FILT_W          = SAMPLE_BITS + FILT_EXT;
    localparam int ALU_W           = 64;
    localparam int ENERGY_W        = 56;
    localparam int COUNT_W         = 24;
    localparam int RMS_W           = 24;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] bmin;
        logic signed [SAMPLE_BITS-1:0] bmax;
        logic                          touched;
        logic [ENERGY_W-1:0]           low_e;
        logic [ENERGY_W-1:0]           mid_e;
        logic [ENERGY_W-1:0]           high_e;
        logic [COUNT_W-1:0]            count;
    } entry_t;

endpackage

/* rtl/tbwb_alu.sv */
// shared iterative unit: shift-add multiply, restoring divide, bitwise square root
module tbwb_alu (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tbwb_pkg::alu_req_t          req,
    input  logic [tbwb_pkg::ALU_W-1:0]  a,
    input  logic [tbwb_pkg::ALU_W-1:0]  b,
    output logic                        done,
    output logic [tbwb_pkg::ALU_W-1:0]  res
);
    import tbwb_pkg::*;

    localparam logic [5:0] DIV_LAST  = 6'(ALU_W - 1);
    localparam logic [5:0] SQRT_LAST = 6'(ALU_W / 2 - 1);
    localparam logic [ALU_W-1:0] SQRT_TOP = ALU_W'(1) << (ALU_W - 2);

    logic             busy_reg;
    logic             done_reg;
    alu_op_t          op_reg;
    logic [ALU_W-1:0] acc_reg;
    logic [ALU_W-1:0] x_reg;
    logic [ALU_W-1:0] y_reg;
    logic [ALU_W-1:0] q_reg;
    logic [ALU_W-1:0] res_reg;
    logic [5:0]       cnt_reg;

    logic [ALU_W-1:0] op_a;
    logic [ALU_W-1:0] op_b;
    logic             sub;
    logic [ALU_W:0]   sum;
    logic             ge;

    always_comb begin
        unique case (op_reg)
            ALU_DIV: begin
                op_a = {acc_reg[ALU_W-2:0], x_reg[ALU_W-1]};
                op_b = y_reg;
                sub  = 1'b1;
            end
            ALU_SQRT: begin
                op_a = acc_reg;
                op_b = q_reg | y_reg;
                sub  = 1'b1;
            end
            default: begin
                op_a = acc_reg;
                op_b = x_reg;
                sub  = 1'b0;
            end
        endcase
        sum = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)} + (ALU_W + 1)'(sub);
        ge  = sum[ALU_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= '0;
                q_reg    <= '0;
                x_reg    <= a;
                y_reg    <= (req.op == ALU_SQRT) ? SQRT_TOP : b;
                acc_reg  <= (req.op == ALU_SQRT) ? a : '0;
            end else if (busy_reg) begin
                unique case (op_reg)
                    ALU_MUL: begin
                        if (y_reg == '0) begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                            res_reg  <= acc_reg;
                        end else begin
                            if (y_reg[0]) acc_reg <= sum[ALU_W-1:0];
                            x_reg <= x_reg << 1;
                            y_reg <= y_reg >> 1;
                        end
                    end
                    ALU_DIV: begin
                        acc_reg <= ge ? sum[ALU_W-1:0] : op_a;
                        q_reg   <= {q_reg[ALU_W-2:0], ge};
                        x_reg   <= x_reg << 1;
                        cnt_reg <= cnt_reg + 6'd1;
                        if (cnt_reg == DIV_LAST) begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                            res_reg  <= {q_reg[ALU_W-2:0], ge};
                        end
                    end
                    ALU_SQRT: begin
                        if (ge) acc_reg <= sum[ALU_W-1:0];
                        q_reg   <= ge ? ((q_reg >> 1) | y_reg) : (q_reg >> 1);
                        y_reg   <= y_reg >> 2;
                        cnt_reg <= cnt_reg + 6'd1;
                        if (cnt_reg == SQRT_LAST) begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                            res_reg  <= ge ? ((q_reg >> 1) | y_reg) : (q_reg >> 1);
                        end
                    end
                    default: begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                        res_reg  <= '0;
                    end
                endcase
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

/* rtl/tbwb_store.sv */
// bin store: one wide entry per window bin, with a clearing pass after reset
module tbwb_store #(
    parameter int WINDOW_BINS = tbwb_pkg::WINDOW_BINS_DEF,
    localparam int AW = $clog2(WINDOW_BINS)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tbwb_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]     rd_addr,
    output tbwb_pkg::entry_t  rd_data,
    input  logic [AW-1:0]     wr_addr,
    input  tbwb_pkg::entry_t  wr_data,
    output logic              clr_busy
);
    import tbwb_pkg::*;

    localparam logic [AW-1:0] LAST = AW'(WINDOW_BINS - 1);

    entry_t        mem [WINDOW_BINS];
    entry_t        rd_data_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == LAST) clr_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) rd_data_reg <= mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

/* rtl/three_band_waveform_bins.sv */
// top level: config registers, request sequencer and result register
// work per request: a sample in the window takes a multiply, 64-step divide, two filter
// multiplies and three squares, one outside it the multiply and divide only; a touched-bin
// read three 64-step divides and 32-step square roots, an untouched one none; one request at
// a time; multiply, divide and root on one shared 64-bit add/sub unit, one bit per cycle
// reset: after aresetn the store runs a clearing pass over all WINDOW_BINS entries with s_ready low
module three_band_waveform_bins #(
    parameter int WINDOW_BINS = tbwb_pkg::WINDOW_BINS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_req_type,
    input  logic [35:0]                            s_sample_index,
    input  logic signed [tbwb_pkg::SAMPLE_BITS-1:0] s_left_sample,
    input  logic signed [tbwb_pkg::SAMPLE_BITS-1:0] s_right_sample,
    input  logic [9:0]                             s_read_bin,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [tbwb_pkg::SAMPLE_BITS-1:0] m_bin_min,
    output logic signed [tbwb_pkg::SAMPLE_BITS-1:0] m_bin_max,
    output logic [tbwb_pkg::RMS_W-1:0]             m_low_rms,
    output logic [tbwb_pkg::RMS_W-1:0]             m_mid_rms,
    output logic [tbwb_pkg::RMS_W-1:0]             m_high_rms,
    output logic                                   m_bin_touched,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [5:0]                             paddr,
    input  logic [63:0]                            pwdata,
    output logic [63:0]                            prdata,
    output logic                                   pready
);
    import tbwb_pkg::*;

    localparam int AW = $clog2(WINDOW_BINS);
    localparam int SB = SAMPLE_BITS;

    localparam logic [1:0] REQ_SAMPLE  = 2'd0;
    localparam logic [1:0] REQ_READ    = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    localparam logic [2:0] REG_CHANNELS  = 3'd0;
    localparam logic [2:0] REG_TOTAL     = 3'd1;
    localparam logic [2:0] REG_SPAN      = 3'd2;
    localparam logic [2:0] REG_WSTART    = 3'd3;
    localparam logic [2:0] REG_WCOUNT    = 3'd4;
    localparam logic [2:0] REG_ALPHA_LOW = 3'd5;
    localparam logic [2:0] REG_ALPHA_MID = 3'd6;

    localparam logic [23:0] WB = 24'(WINDOW_BINS);
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP_MUL,
        ST_MAP_DIV,
        ST_LOOKUP,
        ST_FETCH,
        ST_FLT_LOW,
        ST_FLT_MID,
        ST_SQ_LOW,
        ST_SQ_MID,
        ST_SQ_HIGH,
        ST_WRITE,
        ST_RMS_DIV,
        ST_RMS_SQRT,
        ST_CLEAR,
        ST_OUT
    } state_t;

    function automatic logic [FILT_W-1:0] filt_next(input logic [FILT_W-1:0] f,
                                                    input logic neg,
                                                    input logic [ALU_W-1:0] p);
        logic [49:0]       q;
        logic [FILT_W+1:0] s;
        begin
            q = neg ? (({1'b0, p[48:0]} + 50'h0FFFF) >> 16) : ({1'b0, p[48:0]} >> 16);
            s = {{2{f[FILT_W-1]}}, f} + (neg ? -((FILT_W + 2)'(q)) : (FILT_W + 2)'(q));
            return s[FILT_W-1:0];
        end
    endfunction

    function automatic logic [SB:0] abs_band(input logic [SB:0] v);
        return v[SB] ? (~v + (SB + 1)'(1)) : v;
    endfunction

    function automatic logic [ENERGY_W-1:0] sat_add(input logic [ENERGY_W-1:0] e,
                                                    input logic [ALU_W-1:0] p);
        logic [ENERGY_W:0] s;
        begin
            s = {1'b0, e} + (ENERGY_W + 1)'(p[49:0]);
            return s[ENERGY_W] ? ENERGY_MAX : s[ENERGY_W-1:0];
        end
    endfunction

    function automatic logic [RMS_W-1:0] sat_rms(input logic [ALU_W-1:0] v);
        return (|v[ALU_W-1:RMS_W]) ? {RMS_W{1'b1}} : v[RMS_W-1:0];
    endfunction

    // config registers
    logic [1:0]  ch_reg;
    logic [23:0] total_reg;
    logic [35:0] span_reg;
    logic [23:0] wstart_reg;
    logic [10:0] wcount_reg;
    logic [15:0] alow_reg;
    logic [15:0] amid_reg;
    logic [2:0]  reg_idx;

    assign reg_idx = paddr[5:3];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_reg     <= 2'd2;
            total_reg  <= 24'd1024;
            span_reg   <= 36'd1048576;
            wstart_reg <= 24'd0;
            wcount_reg <= 11'd1024;
            alow_reg   <= 16'd1816;
            amid_reg   <= 16'd14534;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_CHANNELS:  ch_reg     <= pwdata[1:0];
                REG_TOTAL:     total_reg  <= pwdata[23:0];
                REG_SPAN:      span_reg   <= pwdata[35:0];
                REG_WSTART:    wstart_reg <= pwdata[23:0];
                REG_WCOUNT:    wcount_reg <= pwdata[10:0];
                REG_ALPHA_LOW: alow_reg   <= pwdata[15:0];
                REG_ALPHA_MID: amid_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CHANNELS:  prdata = 64'(ch_reg);
            REG_TOTAL:     prdata = 64'(total_reg);
            REG_SPAN:      prdata = 64'(span_reg);
            REG_WSTART:    prdata = 64'(wstart_reg);
            REG_WCOUNT:    prdata = 64'(wcount_reg);
            REG_ALPHA_LOW: prdata = 64'(alow_reg);
            REG_ALPHA_MID: prdata = 64'(amid_reg);
            default:       prdata = '0;
        endcase
    end

    // sequencer state
    state_t                  state;
    logic                    go_reg;
    logic [1:0]              req_reg;
    logic [35:0]             idx_reg;
    logic signed [SB-1:0]    l_reg;
    logic signed [SB-1:0]    r_reg;
    logic [AW-1:0]           li_reg;
    logic [ALU_W-1:0]        tmp_reg;
    logic [FILT_W-1:0]       low_f_reg;
    logic [FILT_W-1:0]       mid_f_reg;
    entry_t                  ent_reg;
    logic                    hit_reg;
    logic [1:0]              band_reg;
    logic [RMS_W-1:0]        rms_low_reg;
    logic [RMS_W-1:0]        rms_mid_reg;
    logic [RMS_W-1:0]        rms_high_reg;
    logic                    m_valid_reg;
    logic signed [SB-1:0]    out_min_reg;
    logic signed [SB-1:0]    out_max_reg;
    logic [RMS_W-1:0]        out_low_reg;
    logic [RMS_W-1:0]        out_mid_reg;
    logic [RMS_W-1:0]        out_high_reg;
    logic                    out_touched_reg;

    // datapath around the shared unit
    logic [SB:0]             lr_sum;
    logic signed [SB-1:0]    x;
    logic [FILT_W-1:0]       xe;
    logic                    win_ok;
    logic [23:0]             safe_a;
    logic [23:0]             safe_b;
    logic [23:0]             safe;
    logic [35:0]             span1;
    logic [ALU_W-1:0]        local_bin;
    logic                    hit_win;
    logic [FILT_W:0]         d_lo;
    logic [FILT_W:0]         d_md;
    logic [FILT_W:0]         d_mid_low;
    logic [FILT_W:0]         d_high;
    logic [FILT_W:0]         mag_lo;
    logic [FILT_W:0]         mag_md;
    logic [SB:0]             sq_lo;
    logic [SB:0]             sq_md;
    logic [SB:0]             sq_hi;
    logic [ENERGY_W-1:0]     energy_sel;
    logic [COUNT_W-1:0]      cnt1;
    entry_t                  new_ent;

    alu_req_t                alu_req;
    logic [ALU_W-1:0]        alu_a;
    logic [ALU_W-1:0]        alu_b;
    logic                    alu_done;
    logic [ALU_W-1:0]        alu_res;

    mem_ctl_t                mem_ctl;
    logic [AW-1:0]           rd_addr;
    entry_t                  rd_data;
    entry_t                  wr_data;
    logic                    clr_busy;

    assign lr_sum = {l_reg[SB-1], l_reg} + {r_reg[SB-1], r_reg};
    assign x      = (ch_reg <= 2'd1 || MAX_CHANNELS < 2) ? l_reg : lr_sum[SB:1];
    assign xe     = {x, {FILT_EXT{1'b0}}};

    assign win_ok    = (total_reg != 24'd0) && (wstart_reg < total_reg);
    assign safe_a    = total_reg - wstart_reg;
    assign safe_b    = (24'(wcount_reg) < safe_a) ? 24'(wcount_reg) : safe_a;
    assign safe      = (safe_b > WB) ? WB : safe_b;
    assign span1     = (span_reg == 36'd0) ? 36'd1 : span_reg;
    assign local_bin = tmp_reg - ALU_W'(wstart_reg);
    assign hit_win   = win_ok && (tmp_reg >= ALU_W'(wstart_reg))
                       && (local_bin < ALU_W'(safe));

    assign d_lo      = {xe[FILT_W-1], xe} - {low_f_reg[FILT_W-1], low_f_reg};
    assign d_md      = {xe[FILT_W-1], xe} - {mid_f_reg[FILT_W-1], mid_f_reg};
    assign d_mid_low = {mid_f_reg[FILT_W-1], mid_f_reg} - {low_f_reg[FILT_W-1], low_f_reg};
    assign d_high    = d_md;
    assign mag_lo    = d_lo[FILT_W] ? (~d_lo + (FILT_W + 1)'(1)) : d_lo;
    assign mag_md    = d_md[FILT_W] ? (~d_md + (FILT_W + 1)'(1)) : d_md;
    assign sq_lo     = abs_band({low_f_reg[FILT_W-1], low_f_reg[FILT_W-1:FILT_EXT]});
    assign sq_md     = abs_band(d_mid_low[FILT_W:FILT_EXT]);
    assign sq_hi     = abs_band(d_high[FILT_W:FILT_EXT]);

    assign energy_sel = (band_reg == 2'd0) ? ent_reg.low_e :
                        (band_reg == 2'd1) ? ent_reg.mid_e : ent_reg.high_e;
    assign cnt1       = (ent_reg.count == '0) ? COUNT_W'(1) : ent_reg.count;

    always_comb begin
        new_ent         = ent_reg;
        new_ent.touched = 1'b1;
        if (!ent_reg.touched) begin
            new_ent.bmin = x;
            new_ent.bmax = x;
        end else begin
            if (x < $signed(ent_reg.bmin)) new_ent.bmin = x;
            if (x > $signed(ent_reg.bmax)) new_ent.bmax = x;
        end
        if (!(&ent_reg.count)) new_ent.count = ent_reg.count + COUNT_W'(1);
    end

    always_comb begin
        alu_req.start = go_reg;
        alu_req.op    = ALU_MUL;
        alu_a         = '0;
        alu_b         = '0;
        unique case (state)
            ST_MAP_MUL: begin
                alu_a = ALU_W'(idx_reg);
                alu_b = ALU_W'(total_reg);
            end
            ST_MAP_DIV: begin
                alu_req.op = ALU_DIV;
                alu_a      = tmp_reg;
                alu_b      = ALU_W'(span1);
            end
            ST_FLT_LOW: begin
                alu_a = ALU_W'(mag_lo);
                alu_b = ALU_W'(alow_reg);
            end
            ST_FLT_MID: begin
                alu_a = ALU_W'(mag_md);
                alu_b = ALU_W'(amid_reg);
            end
            ST_SQ_LOW: begin
                alu_a = ALU_W'(sq_lo);
                alu_b = ALU_W'(sq_lo);
            end
            ST_SQ_MID: begin
                alu_a = ALU_W'(sq_md);
                alu_b = ALU_W'(sq_md);
            end
            ST_SQ_HIGH: begin
                alu_a = ALU_W'(sq_hi);
                alu_b = ALU_W'(sq_hi);
            end
            ST_RMS_DIV: begin
                alu_req.op = ALU_DIV;
                alu_a      = ALU_W'(energy_sel);
                alu_b      = ALU_W'(cnt1);
            end
            ST_RMS_SQRT: begin
                alu_req.op = ALU_SQRT;
                alu_a      = tmp_reg;
            end
            default: ;
        endcase
    end

    assign mem_ctl.rd_en = (state == ST_LOOKUP) && ((req_reg == REQ_READ) || hit_win);
    assign mem_ctl.wr_en = (state == ST_WRITE) || (state == ST_CLEAR);
    assign rd_addr       = (req_reg == REQ_READ) ? li_reg : AW'(local_bin);
    assign wr_data       = (state == ST_CLEAR) ? entry_t'('0) : new_ent;

    assign s_ready = (state == ST_IDLE) && !clr_busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state       <= ST_IDLE;
            go_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            low_f_reg   <= '0;
            mid_f_reg   <= '0;
        end else begin
            go_reg <= 1'b0;
            if (m_valid_reg && m_ready && (state != ST_OUT)) m_valid_reg <= 1'b0;
            unique case (state)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        req_reg <= s_req_type;
                        idx_reg <= s_sample_index;
                        l_reg   <= s_left_sample;
                        r_reg   <= s_right_sample;
                        li_reg  <= AW'(s_read_bin);
                        unique case (s_req_type)
                            REQ_SAMPLE: begin
                                state  <= ST_MAP_MUL;
                                go_reg <= 1'b1;
                            end
                            REQ_READ: begin
                                if (32'(s_read_bin) >= WINDOW_BINS) begin
                                    hit_reg <= 1'b0;
                                    state   <= ST_OUT;
                                end else begin
                                    state <= ST_LOOKUP;
                                end
                            end
                            REQ_RESTART: begin
                                low_f_reg <= '0;
                                mid_f_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MAP_MUL: begin
                    if (alu_done) begin
                        tmp_reg <= alu_res;
                        state   <= ST_MAP_DIV;
                        go_reg  <= 1'b1;
                    end
                end
                ST_MAP_DIV: begin
                    if (alu_done) begin
                        tmp_reg <= alu_res;
                        state   <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP: begin
                    if (req_reg == REQ_READ) begin
                        state <= ST_FETCH;
                    end else if (hit_win) begin
                        li_reg <= AW'(local_bin);
                        state  <= ST_FETCH;
                    end else begin
                        state <= ST_IDLE;
                    end
                end
                ST_FETCH: begin
                    ent_reg  <= rd_data;
                    band_reg <= 2'd0;
                    if (req_reg == REQ_READ) begin
                        hit_reg <= rd_data.touched;
                        if (rd_data.touched) begin
                            state  <= ST_RMS_DIV;
                            go_reg <= 1'b1;
                        end else begin
                            state <= ST_CLEAR;
                        end
                    end else begin
                        state  <= ST_FLT_LOW;
                        go_reg <= 1'b1;
                    end
                end
                ST_FLT_LOW: begin
                    if (alu_done) begin
                        low_f_reg <= filt_next(low_f_reg, d_lo[FILT_W], alu_res);
                        state     <= ST_FLT_MID;
                        go_reg    <= 1'b1;
                    end
                end
                ST_FLT_MID: begin
                    if (alu_done) begin
                        mid_f_reg <= filt_next(mid_f_reg, d_md[FILT_W], alu_res);
                        state     <= ST_SQ_LOW;
                        go_reg    <= 1'b1;
                    end
                end
                ST_SQ_LOW: begin
                    if (alu_done) begin
                        ent_reg.low_e <= sat_add(ent_reg.low_e, alu_res);
                        state         <= ST_SQ_MID;
                        go_reg        <= 1'b1;
                    end
                end
                ST_SQ_MID: begin
                    if (alu_done) begin
                        ent_reg.mid_e <= sat_add(ent_reg.mid_e, alu_res);
                        state         <= ST_SQ_HIGH;
                        go_reg        <= 1'b1;
                    end
                end
                ST_SQ_HIGH: begin
                    if (alu_done) begin
                        ent_reg.high_e <= sat_add(ent_reg.high_e, alu_res);
                        state          <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    state <= ST_IDLE;
                end
                ST_RMS_DIV: begin
                    if (alu_done) begin
                        tmp_reg <= alu_res;
                        state   <= ST_RMS_SQRT;
                        go_reg  <= 1'b1;
                    end
                end
                ST_RMS_SQRT: begin
                    if (alu_done) begin
                        if (band_reg == 2'd0) rms_low_reg <= sat_rms(alu_res);
                        if (band_reg == 2'd1) rms_mid_reg <= sat_rms(alu_res);
                        if (band_reg == 2'd2) rms_high_reg <= sat_rms(alu_res);
                        if (band_reg == 2'd2) begin
                            state <= ST_CLEAR;
                        end else begin
                            band_reg <= band_reg + 2'd1;
                            state    <= ST_RMS_DIV;
                            go_reg   <= 1'b1;
                        end
                    end
                end
                ST_CLEAR: begin
                    state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg     <= 1'b1;
                        out_min_reg     <= hit_reg ? ent_reg.bmin : '0;
                        out_max_reg     <= hit_reg ? ent_reg.bmax : '0;
                        out_low_reg     <= hit_reg ? rms_low_reg : '0;
                        out_mid_reg     <= hit_reg ? rms_mid_reg : '0;
                        out_high_reg    <= hit_reg ? rms_high_reg : '0;
                        out_touched_reg <= hit_reg;
                        state           <= ST_IDLE;
                    end
                end
                default: state <= ST_IDLE;
            endcase
        end
    end

    tbwb_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (alu_a),
        .b       (alu_b),
        .done    (alu_done),
        .res     (alu_res)
    );

    tbwb_store #(
        .WINDOW_BINS (WINDOW_BINS)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (mem_ctl),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_addr  (li_reg),
        .wr_data  (wr_data),
        .clr_busy (clr_busy)
    );

    assign m_valid       = m_valid_reg;
    assign m_bin_min     = out_min_reg;
    assign m_bin_max     = out_max_reg;
    assign m_low_rms     = out_low_reg;
    assign m_mid_rms     = out_mid_reg;
    assign m_high_rms    = out_high_reg;
    assign m_bin_touched = out_touched_reg;

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && ((s_req_type == REQ_SAMPLE) || (s_req_type == REQ_READ)))
        |=> !s_ready)
        else $error("new beat accepted while a request is in progress");

    a_no_accept_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_ready)
        else $error("input ready during store clearing pass");

    a_alu_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_done |-> (state != ST_IDLE))
        else $error("shared unit finished while sequencer idle");

    a_no_rd_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_ctl.rd_en && mem_ctl.wr_en))
        else $error("store read and write in the same cycle");
`endif

endmodule
